// ===== design/accalu_pkg.sv =====
package accalu_pkg;

  // Operation codes carried in the action field
  typedef enum logic [3:0] {
    ACT_ADD   = 4'd0,
    ACT_ADC   = 4'd1,
    ACT_SUB   = 4'd2,
    ACT_SBC   = 4'd3,
    ACT_CP    = 4'd4,
    ACT_INC8  = 4'd5,
    ACT_DEC8  = 4'd6,
    ACT_ADDHL = 4'd7,
    ACT_ADDSP = 4'd8,
    ACT_INC16 = 4'd9,
    ACT_DEC16 = 4'd10,
    ACT_CCF   = 4'd11,
    ACT_SCF   = 4'd12
  } action_t;

  // Operand source codes (code 3 behaves like immediate)
  localparam logic [1:0] SRC_REG = 2'd0;
  localparam logic [1:0] SRC_MEM = 2'd1;
  localparam logic [1:0] SRC_IMM = 2'd2;

  localparam int ActW   = 4;
  localparam int WordW  = 16;
  localparam int SrcW   = 2;
  localparam int CycW   = 3;

  // Flag register, Z in the top bit down to C
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  // One decoded instruction held in the input register
  typedef struct packed {
    logic [ActW-1:0]  act;
    logic [WordW-1:0] operand;
    logic [WordW-1:0] base_word;
    logic [SrcW-1:0]  src;
  } req_t;

  // Everything the execute logic produces for one word
  typedef struct packed {
    logic [7:0]       acc;
    flags_t           flags;
    logic [WordW-1:0] word;
    logic [CycW-1:0]  cycles;
  } res_t;

endpackage

// ===== design/accumulator_alu_with_flags_unit.sv =====
// SM83-style accumulator ALU. Each input word carries one operation (ADD, ADC,
// SUB, SBC, CP, INC8, DEC8, ADD HL, ADD SP, INC16, DEC16, CCF, SCF), its operand,
// the HL/SP base word and the operand source; the block keeps A and the ZNHC
// flags and returns for each word the new A, the flags, a 16-bit result for
// the inc/dec or pointer target, and the instruction's machine-cycle count.
// Unknown action codes leave A and the flags alone and report one cycle.
// Throughput is one word per clock while no result waits on m_axis_tready.
// An accepted word passes the input register, then execute into the output
// register, where the result word goes valid.
// While a result waits on m_axis_tready a word in the input register is held
// and s_axis_tready stays low; an empty input register can still take one word.
// A and the flags update in the same edge that loads the output register, so
// a word that follows immediately already sees the previous result.
// Reset clears A and all flags.
module accumulator_alu_with_flags_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] action, [19:4] operand, [35:20] base_word, [39:36] zero
  input  logic [39:0] s_axis_tdata,
  // [1:0] operand_source
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] acc_out, [8] flag_zero, [9] flag_subtract, [10] flag_half,
  // [11] flag_carry, [27:12] result_word, [30:28] machine_cycles, [31] zero
  output logic [31:0] m_axis_tdata
);

  // input register
  logic               in_valid;
  accalu_pkg::req_t   in_req;

  // architectural state
  logic [7:0]         accumulator;
  accalu_pkg::flags_t flag_bits;

  // output register
  logic               out_valid;
  accalu_pkg::res_t   out_res;

  accalu_pkg::res_t   exec_res;
  logic               advance;

  // the execute stage moves whenever the output register is free or draining
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  accalu_exec u_exec (
    .req   (in_req),
    .acc   (accumulator),
    .flags (flag_bits),
    .res   (exec_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req.act       <= s_axis_tdata[3:0];
      in_req.operand   <= s_axis_tdata[19:4];
      in_req.base_word <= s_axis_tdata[35:20];
      in_req.src       <= s_axis_tuser;
    end
  end

  // state commits exactly once per word, when it leaves execute
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      flag_bits   <= '0;
    end else if (advance) begin
      accumulator <= exec_res.acc;
      flag_bits   <= exec_res.flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= exec_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_res.cycles, out_res.word, out_res.flags.c,
                          out_res.flags.h, out_res.flags.n, out_res.flags.z,
                          out_res.acc};

endmodule

// ===== design/accalu_exec.sv =====
module accalu_exec (
  input  accalu_pkg::req_t   req,
  input  logic [7:0]         acc,
  input  accalu_pkg::flags_t flags,
  output accalu_pkg::res_t   res
);

  logic [7:0]  v;
  logic        cin;
  logic [8:0]  sum8;
  logic [4:0]  sum4;
  logic [8:0]  dif8;
  logic [4:0]  dif4;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic [16:0] sum16;
  logic [12:0] sum12;
  logic [15:0] ext;
  logic [8:0]  splo8;
  logic [4:0]  splo4;
  logic [2:0]  alu_cyc;
  logic [2:0]  mem_cyc;

  assign v     = req.operand[7:0];
  assign sum8  = {1'b0, acc} + {1'b0, v} + {8'd0, cin};
  assign sum4  = {1'b0, acc[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
  assign dif8  = {1'b0, acc} - {1'b0, v} - {8'd0, cin};
  assign dif4  = {1'b0, acc[3:0]} - {1'b0, v[3:0]} - {4'd0, cin};
  assign inc8  = v + 8'd1;
  assign dec8  = v - 8'd1;
  assign sum16 = {1'b0, req.base_word} + {1'b0, req.operand};
  assign sum12 = {1'b0, req.base_word[11:0]} + {1'b0, req.operand[11:0]};
  assign ext   = {{8{v[7]}}, v};
  assign splo8 = {1'b0, req.base_word[7:0]} + {1'b0, v};
  assign splo4 = {1'b0, req.base_word[3:0]} + {1'b0, v[3:0]};
  assign alu_cyc = (req.src == accalu_pkg::SRC_REG) ? 3'd1 : 3'd2;
  assign mem_cyc = (req.src == accalu_pkg::SRC_MEM) ? 3'd3 : 3'd1;

  // carry/borrow in only for the with-carry forms
  always_comb begin
    case (accalu_pkg::action_t'(req.act))
      accalu_pkg::ACT_ADC, accalu_pkg::ACT_SBC: cin = flags.c;
      default:                                  cin = 1'b0;
    endcase
  end

  always_comb begin
    res.acc    = acc;
    res.flags  = flags;
    res.word   = '0;
    res.cycles = 3'd1;
    case (accalu_pkg::action_t'(req.act))
      accalu_pkg::ACT_ADD, accalu_pkg::ACT_ADC: begin
        res.acc    = sum8[7:0];
        res.flags  = '{z: (sum8[7:0] == 8'd0), n: 1'b0, h: sum4[4], c: sum8[8]};
        res.cycles = alu_cyc;
      end
      accalu_pkg::ACT_SUB, accalu_pkg::ACT_SBC: begin
        res.acc    = dif8[7:0];
        res.flags  = '{z: (dif8[7:0] == 8'd0), n: 1'b1, h: dif4[4], c: dif8[8]};
        res.cycles = alu_cyc;
      end
      accalu_pkg::ACT_CP: begin
        res.flags  = '{z: (dif8[7:0] == 8'd0), n: 1'b1, h: dif4[4], c: dif8[8]};
        res.cycles = alu_cyc;
      end
      accalu_pkg::ACT_INC8: begin
        res.flags  = '{z: (inc8 == 8'd0), n: 1'b0, h: (v[3:0] == 4'hF), c: flags.c};
        res.word   = {8'd0, inc8};
        res.cycles = mem_cyc;
      end
      accalu_pkg::ACT_DEC8: begin
        res.flags  = '{z: (dec8 == 8'd0), n: 1'b1, h: (v[3:0] == 4'h0), c: flags.c};
        res.word   = {8'd0, dec8};
        res.cycles = mem_cyc;
      end
      accalu_pkg::ACT_ADDHL: begin
        res.flags  = '{z: flags.z, n: 1'b0, h: sum12[12], c: sum16[16]};
        res.word   = sum16[15:0];
        res.cycles = 3'd2;
      end
      accalu_pkg::ACT_ADDSP: begin
        res.flags  = '{z: 1'b0, n: 1'b0, h: splo4[4], c: splo8[8]};
        res.word   = req.base_word + ext;
        res.cycles = 3'd4;
      end
      accalu_pkg::ACT_INC16: begin
        res.word   = req.operand + 16'd1;
        res.cycles = 3'd2;
      end
      accalu_pkg::ACT_DEC16: begin
        res.word   = req.operand - 16'd1;
        res.cycles = 3'd2;
      end
      accalu_pkg::ACT_CCF: begin
        res.flags  = '{z: flags.z, n: 1'b0, h: 1'b0, c: ~flags.c};
      end
      accalu_pkg::ACT_SCF: begin
        res.flags  = '{z: flags.z, n: 1'b0, h: 1'b0, c: 1'b1};
      end
      default: begin
        res.acc = acc;  // unknown codes change nothing
      end
    endcase
  end

endmodule
